// ----- hdl/bcbc_pkg.sv -----
package bcbc_pkg;

  localparam int BLK_W   = 32;
  localparam int INO_W   = 16;
  localparam int USED_W  = 17;
  localparam int CNT_W   = 32;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 136;
  localparam int ROW_W   = 8;   // bitmap bits per memory row
  localparam int ROW_SEL = 3;   // offset bits that pick a bit within a row

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_END   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_INODE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK      = 8'd3;

  // first nonzero block that can be a bad-block record
  localparam logic [BLK_W-1:0] RECORD_FIRST = 32'd2;

  typedef enum logic [1:0] {
    STAT_CLAIMED = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_DUP     = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [INO_W-1:0]    prev;
    logic [USED_W-1:0]   used;
    logic [CNT_W-1:0]    bad;
    logic [CNT_W-1:0]    dup;
    logic [CNT_W-1:0]    err;
  } res_t;

endpackage

// ----- hdl/bcbc_ram.sv -----
module bcbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/block_claim_bitmap_checker.sv -----
// Block claim bitmap checker.
// Input stream (in_*): one block reference per transaction; tdata carries the
// block number and the referencing inode. Result stream (out_*): one result
// per reference, in order; tuser carries the status, tdata the recorded owner
// and the running used, bad, duplicate and error totals (after the update).
// Config channel (cfg_*): register index plus data, always ready; write only
// while no reference is in flight.
// Timing: the bitmap and owner RAM reads are issued at the accepting edge; the
// next cycle does the read-modify-write of the bitmap row and registers the
// result into the output or skid register. in_tready is low in that cycle, so
// the block takes no new reference until the previous one is finished.
// A finished result waits in the output register; one more reference may be
// accepted and finished into a skid register behind it, after which in_tready
// stays low until the receiver takes a result.
// Reset: counters and config clear at once; the bitmap RAM is then cleared
// one 8-bit row per cycle, (DATA_BLOCKS+7)/8 rows (8192 by default),
// with in_tready low. Config writes are taken during the clear.
module block_claim_bitmap_checker #(
  parameter int DATA_BLOCKS = 65536,
  parameter int INODE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // [31:0] block_number, [47:32] inode_number
  input  logic [bcbc_pkg::IN_W-1:0]      in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] previous_owner, [32:16] used_total, [64:33] bad_total,
  // [96:65] duplicate_total, [128:97] error_total, [135:129] zero
  output logic [bcbc_pkg::OUT_W-1:0]     out_tdata,
  // [1:0] status
  output logic [1:0]                     out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcbc_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int ROWS   = (DATA_BLOCKS + bcbc_pkg::ROW_W - 1) / bcbc_pkg::ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OWN_AW = $clog2(DATA_BLOCKS);
  localparam int IW_MIN = (INODE_BITS < bcbc_pkg::INO_W) ? INODE_BITS : bcbc_pkg::INO_W;
  localparam logic [ROW_AW-1:0]            LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [bcbc_pkg::BLK_W-1:0]   CAPACITY = bcbc_pkg::BLK_W'(DATA_BLOCKS);
  localparam logic [bcbc_pkg::USED_W-1:0]  USED_MAX = '1;
  localparam logic [bcbc_pkg::CNT_W-1:0]   CNT_MAX  = '1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_BUSY} state_t;

  state_t state_r, state_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;

  // configuration
  logic [bcbc_pkg::BLK_W-1:0] start_r, end_r;
  logic [bcbc_pkg::INO_W-1:0] bad_ino_r;
  logic                       track_r;

  // counters
  logic [bcbc_pkg::USED_W-1:0] used_r, used_nxt;
  logic [bcbc_pkg::CNT_W-1:0]  bad_r, bad_nxt, dup_r, dup_nxt, err_r, err_nxt;

  // item in flight
  bcbc_pkg::status_t       cls_r, cls_nxt;
  logic [bcbc_pkg::ROW_SEL-1:0] bsel_r;
  logic [ROW_AW-1:0]       row_r;
  logic [OWN_AW-1:0]       own_addr_r;
  logic [INODE_BITS-1:0]   own_wd_r, own_wd;

  // output register and skid
  logic            out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  bcbc_pkg::res_t  out_res_r, out_res_nxt, skid_res_r, skid_res_nxt, res;

  // input decode
  logic [bcbc_pkg::BLK_W-1:0] blk, off;
  logic [bcbc_pkg::INO_W-1:0] ino, ino_m;
  logic in_region, is_record, accept;

  // memories
  logic                     bm_we, own_we;
  logic [ROW_AW-1:0]        bm_waddr;
  logic [bcbc_pkg::ROW_W-1:0] bm_wdata, bm_rdata, bit_mask;
  logic [INODE_BITS-1:0]    own_rdata;
  logic                     hit, claim_new;

  assign blk    = in_tdata[31:0];
  assign ino    = in_tdata[47:32];
  assign off    = blk - start_r;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    ino_m = '0;
    ino_m[IW_MIN-1:0] = ino[IW_MIN-1:0];
    own_wd = '0;
    own_wd[IW_MIN-1:0] = ino[IW_MIN-1:0];
  end

  assign in_region = (blk >= start_r) && (blk < end_r) && (off < CAPACITY);
  assign is_record = (bad_ino_r != '0) && (ino_m == bad_ino_r) &&
                     (blk >= bcbc_pkg::RECORD_FIRST) && (blk < start_r);

  always_comb begin
    priority if (blk == '0) begin
      cls_nxt = bcbc_pkg::STAT_IGNORED;
    end else if (in_region) begin
      cls_nxt = bcbc_pkg::STAT_CLAIMED;   // becomes duplicate if the bit is set
    end else if (is_record) begin
      cls_nxt = bcbc_pkg::STAT_IGNORED;
    end else begin
      cls_nxt = bcbc_pkg::STAT_RANGE;
    end
  end

  assign in_tready = (state_r == S_IDLE) && !skid_valid_r;
  assign cfg_ready = 1'b1;

  // read-modify-write of the addressed row
  assign bit_mask  = bcbc_pkg::ROW_W'(1) << bsel_r;
  assign hit       = |(bm_rdata & bit_mask);
  assign claim_new = (state_r == S_BUSY) && (cls_r == bcbc_pkg::STAT_CLAIMED) && !hit;

  assign bm_we    = (state_r == S_CLEAR) || claim_new;
  assign bm_waddr = (state_r == S_CLEAR) ? clr_row_r : row_r;
  assign bm_wdata = (state_r == S_CLEAR) ? '0 : (bm_rdata | bit_mask);
  assign own_we   = claim_new && track_r;

  bcbc_ram #(.WIDTH(bcbc_pkg::ROW_W), .DEPTH(ROWS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (off[ROW_AW+bcbc_pkg::ROW_SEL-1:bcbc_pkg::ROW_SEL]),
    .rdata (bm_rdata)
  );

  bcbc_ram #(.WIDTH(INODE_BITS), .DEPTH(DATA_BLOCKS)) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_addr_r),
    .wdata (own_wd_r),
    .raddr (off[OWN_AW-1:0]),
    .rdata (own_rdata)
  );

  always_comb begin
    used_nxt = used_r;
    bad_nxt  = bad_r;
    dup_nxt  = dup_r;
    err_nxt  = err_r;
    res      = '0;
    res.status = cls_r;
    if (state_r == S_BUSY) begin
      unique case (cls_r)
        bcbc_pkg::STAT_CLAIMED: begin
          if (hit) begin
            res.status = bcbc_pkg::STAT_DUP;
            if (track_r) begin
              res.prev[IW_MIN-1:0] = own_rdata[IW_MIN-1:0];
            end
            dup_nxt = (dup_r == CNT_MAX) ? dup_r : dup_r + 1'b1;
            err_nxt = (err_r == CNT_MAX) ? err_r : err_r + 1'b1;
          end else begin
            used_nxt = (used_r == USED_MAX) ? used_r : used_r + 1'b1;
          end
        end
        bcbc_pkg::STAT_RANGE: begin
          bad_nxt = (bad_r == CNT_MAX) ? bad_r : bad_r + 1'b1;
          err_nxt = (err_r == CNT_MAX) ? err_r : err_r + 1'b1;
        end
        bcbc_pkg::STAT_IGNORED, bcbc_pkg::STAT_DUP: begin
        end
      endcase
    end
    res.used = used_nxt;
    res.bad  = bad_nxt;
    res.dup  = dup_nxt;
    res.err  = err_nxt;
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    priority if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else if (state_r == S_BUSY) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (state_r == S_BUSY) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end else begin
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_row_r    <= '0;
      start_r      <= '0;
      end_r        <= '0;
      bad_ino_r    <= '0;
      track_r      <= 1'b0;
      used_r       <= '0;
      bad_r        <= '0;
      dup_r        <= '0;
      err_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_row_r    <= clr_row_nxt;
      used_r       <= used_nxt;
      bad_r        <= bad_nxt;
      dup_r        <= dup_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcbc_pkg::CFG_DATA_START: start_r   <= cfg_data;
          bcbc_pkg::CFG_DATA_END:   end_r     <= cfg_data;
          bcbc_pkg::CFG_BAD_INODE:  bad_ino_r <= cfg_data[bcbc_pkg::INO_W-1:0];
          bcbc_pkg::CFG_TRACK:      track_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
    if (accept) begin
      cls_r      <= cls_nxt;
      bsel_r     <= off[bcbc_pkg::ROW_SEL-1:0];
      row_r      <= off[ROW_AW+bcbc_pkg::ROW_SEL-1:bcbc_pkg::ROW_SEL];
      own_addr_r <= off[OWN_AW-1:0];
      own_wd_r   <= own_wd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'b0, out_res_r.err, out_res_r.dup, out_res_r.bad,
                       out_res_r.used, out_res_r.prev};

endmodule

// ----- hdl/bcbc_checker.sv -----
module bcbc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [bcbc_pkg::OUT_W-1:0]     out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one reference in flight: no acceptance in the cycle after one
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("reference accepted while another is in flight");

  // error total covers both bad and duplicate totals
  a_err_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[128:97] >= out_tdata[64:33]) &&
                   (out_tdata[128:97] >= out_tdata[96:65]))
    else $error("error total below a component total");

  // owner only reported on duplicates
  a_prev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != bcbc_pkg::STAT_DUP) |-> out_tdata[15:0] == '0)
    else $error("owner reported on a non-duplicate");

  // a claim always leaves a nonzero used total
  a_claim_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bcbc_pkg::STAT_CLAIMED) |-> out_tdata[32:16] != '0)
    else $error("claim with zero used total");

endmodule

bind block_claim_bitmap_checker bcbc_checker u_bcbc_checker (.*);
